FILE: rtl/core/awm_pkg.sv
// Package for the accelerometer window-mean core: field widths, port packing,
// constant-divisor reciprocals, unit modes and register indexes.
// No dependencies.
package awm_pkg;

   localparam int NUM_AXES     = 3;
   localparam int ACCEL_W      = 10;
   localparam int VALUE_W      = 17;
   localparam int MODE_W       = 2;
   localparam int PERIOD_W     = 8;
   localparam int DEF_WINDOW   = 10;
   localparam logic [PERIOD_W-1:0] DEF_PERIOD = 8'd10;

   // stream packing, padded to whole bytes
   localparam int REQ_TDATA_W  = 32;
   localparam int RSP_TDATA_W  = 56;

   // configuration port
   localparam int CSR_ADDR_W   = 1;
   localparam int CSR_DATA_W   = 8;

   // mean minus reference spans -1023..1023
   localparam int DIFF_W       = 11;
   localparam int MAG_DIFF_W   = 10;

   // |v| / 26 as (|v| * 1261) >> 15, exact for |v| < 2^10
   localparam int DIV26_K      = 15;
   localparam int DIV26_M_W    = 11;
   localparam logic [DIV26_M_W-1:0] DIV26_M = 11'd1261;
   localparam int Q26_W        = 6;

   // v*100/260 reduces to 5v/13; (5|v| * 10083) >> 17, exact for 5|v| < 2^13
   localparam int X5_W         = 13;
   localparam int DIV13_K      = 17;
   localparam int DIV13_M_W    = 14;
   localparam logic [DIV13_M_W-1:0] DIV13_M = 14'd10083;
   localparam int Q13_W        = 9;

   // milli m/s2 per 1/26 step of raw counts
   localparam int MILLI_W      = 16;
   localparam logic [MAG_DIFF_W-1:0] MILLI_SCALE = 10'd981;

   typedef enum logic [MODE_W-1:0] {
      MODE_RAW       = 2'd0,
      MODE_MILLI_MS2 = 2'd1,
      MODE_CENTI_G   = 2'd2
   } mode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_UNIT_MODE     = 1'b0,
      CSR_REPORT_PERIOD = 1'b1
   } csr_index_type;

   // one sample, x in the low bits
   typedef logic [NUM_AXES-1:0][ACCEL_W-1:0] sample_type;

endpackage

FILE: rtl/core/accel_window_mean_with_reference_core.sv
// Top level of the accelerometer window-mean core: boxcar window, running sums,
// reference capture, periodic report and unit conversion pipeline.
// Depends on awm_pkg.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------
//  req     | in  | req_tvalid/req_tready | tdata x,y,z (10b each), tuser capture
//  rsp     | out | rsp_tvalid/rsp_tready | tdata x,y,z (17b each), tuser mode_used
//  csr     | in  | csr_we                | csr_addr index, csr_wdata value
//
//  One sample per cycle while req_tready is high. Sums, window, reference and
//  report counter update in the accepting cycle; a report then runs a
//  three-register pipeline (mean and difference, reciprocal divides, scale and
//  sign) whose first stage loads at the accepting edge; each stage moves on when free.
//  Stalls: req_tready drops only when all three report stages are full and
//  rsp_tready is low; every sample then waits, whether it reports or not.
//  Reset is synchronous; no clearing pass, window taps are not reset and are
//  only read after WINDOW samples have filled them.
module accel_window_mean_with_reference_core
   import awm_pkg::*;
#(
   parameter int WINDOW = DEF_WINDOW    // window length, 2..64
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [9:0] accel_x, [19:10] accel_y,
                                               // [29:20] accel_z, rest zero
   input  logic                   req_tuser,   // [0] capture_reference

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [16:0] value_x, [33:17] value_y,
                                               // [50:34] value_z, rest zero
   output logic [MODE_W-1:0]      rsp_tuser,   // [1:0] mode_used

   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int WIN_LOG   = $clog2(WINDOW);
   localparam int SUM_W     = ACCEL_W + WIN_LOG;
   localparam int MAG_W     = SUM_W;
   // rounded mean: |t| / WINDOW as (|t| * MEAN_M) >> MEAN_K, exact for |t| < 2^MAG_W
   localparam int MEAN_K    = MAG_W + WIN_LOG;
   localparam longint MEAN_M = ((longint'(1) << MEAN_K) + longint'(WINDOW) - 1)
                               / longint'(WINDOW);
   localparam int MEAN_M_W  = $clog2(MEAN_M + 1);
   localparam int PROD_W    = MAG_W + MEAN_M_W;
   localparam int FILL_W    = $clog2(WINDOW + 2);

   localparam logic [MEAN_M_W-1:0] MEAN_M_C = MEAN_M_W'(MEAN_M);

   // ---------------------------------------------------------------- control
   logic                  accept;
   logic                  filling;
   logic                  first_post;
   logic                  eff_cap;
   logic                  report_now;
   logic                  s1_free, s2_free, s3_free;
   mode_type              mode_c;

   logic [MODE_W-1:0]     unit_mode_ff;
   logic [PERIOD_W-1:0]   report_period_ff;
   logic [PERIOD_W-1:0]   report_counter_ff, report_counter_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;

   // window shift line, newest at tap 0
   sample_type            win_ff [WINDOW];
   sample_type            sample_c;

   logic signed [SUM_W-1:0]   sum_ff [NUM_AXES];
   logic signed [SUM_W-1:0]   sum_in [NUM_AXES];
   logic signed [ACCEL_W-1:0] ref_ff [NUM_AXES];
   logic signed [ACCEL_W-1:0] ref_in [NUM_AXES];
   logic signed [ACCEL_W-1:0] mean_c [NUM_AXES];
   logic signed [DIFF_W-1:0]  diff_c [NUM_AXES];

   // report pipeline
   logic                      s1_valid_ff, s1_valid_in;
   logic signed [DIFF_W-1:0]  s1_diff_ff [NUM_AXES];
   mode_type                  s1_mode_ff;

   logic                      s2_valid_ff, s2_valid_in;
   logic                      s2_neg_ff [NUM_AXES];
   logic signed [DIFF_W-1:0]  s2_raw_ff  [NUM_AXES];
   logic [Q26_W-1:0]          s2_q26_ff  [NUM_AXES];
   logic [Q13_W-1:0]          s2_q13_ff  [NUM_AXES];
   mode_type                  s2_mode_ff;

   logic [Q26_W-1:0]          q26_c [NUM_AXES];
   logic [Q13_W-1:0]          q13_c [NUM_AXES];
   logic signed [VALUE_W-1:0] value_c [NUM_AXES];

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff [NUM_AXES];
   mode_type                  rsp_mode_ff;

   // bubbles collapse: a stage takes new data when empty or when it drains
   assign s3_free    = !rsp_valid_ff || rsp_tready;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_tready = s1_free;
   assign accept     = req_tvalid && req_tready;

   assign filling    = fill_ff < FILL_W'(WINDOW);
   // first sample after the fill loads the reference from the fill mean
   assign first_post = fill_ff == FILL_W'(WINDOW);
   assign eff_cap    = req_tuser || first_post;
   assign report_now = !filling && (report_counter_ff >= report_period_ff);

   assign sample_c   = sample_type'(req_tdata[NUM_AXES*ACCEL_W-1:0]);

   always_comb begin
      case (unit_mode_ff)
         MODE_RAW:       mode_c = MODE_RAW;
         MODE_MILLI_MS2: mode_c = MODE_MILLI_MS2;
         default:        mode_c = MODE_CENTI_G;   // unused code 3 too
      endcase
   end

   always_comb begin
      fill_in           = fill_ff;
      report_counter_in = report_counter_ff;
      if (accept) begin
         if (fill_ff != FILL_W'(WINDOW + 1)) begin
            fill_in = fill_ff + FILL_W'(1);
         end
         if (!filling) begin
            report_counter_in = report_now ? PERIOD_W'(1)
                                           : report_counter_ff + PERIOD_W'(1);
         end
      end
   end

   assign s1_valid_in  = s1_free ? (accept && report_now) : s1_valid_ff;
   assign s2_valid_in  = s2_free ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = s3_free ? s2_valid_ff : rsp_valid_ff;

   // ---------------------------------------------------------------- per axis
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      logic signed [ACCEL_W-1:0] sample_s;
      logic signed [ACCEL_W-1:0] oldest_s;
      logic [SUM_W+1:0]          dbl_plus_w;
      logic [SUM_W+1:0]          half_src;
      logic [SUM_W:0]            t_val;
      logic                      t_neg;
      logic [SUM_W:0]            t_abs;
      logic [MAG_W-1:0]          t_mag;
      logic [PROD_W-1:0]         mean_prod;
      logic [ACCEL_W-1:0]        mean_q;
      logic                      d_neg;
      logic [DIFF_W-1:0]         d_abs_full;
      logic [MAG_DIFF_W-1:0]     d_abs;
      logic [MAG_DIFF_W+DIV26_M_W-1:0] p26;
      logic [X5_W-1:0]           x5;
      logic [X5_W+DIV13_M_W-1:0] p13;
      logic [MILLI_W-1:0]        milli_mag;
      logic [VALUE_W-1:0]        conv_mag;

      assign sample_s = $signed(sample_c[a]);
      assign oldest_s = $signed(win_ff[WINDOW-1][a]);

      // running sum; the oldest tap only counts once the window is full
      assign sum_in[a] = filling
         ? sum_ff[a] + SUM_W'(sample_s)
         : sum_ff[a] + SUM_W'(sample_s) - SUM_W'(oldest_s);

      // mean of the window before this sample: trunc(trunc((2s+W)/2)/W)
      assign dbl_plus_w = {sum_ff[a][SUM_W-1], sum_ff[a], 1'b0} + (SUM_W+2)'(WINDOW);
      assign half_src   = dbl_plus_w + (SUM_W+2)'(dbl_plus_w[SUM_W+1]);
      assign t_val      = half_src[SUM_W+1:1];
      assign t_neg      = t_val[SUM_W];
      assign t_abs      = t_neg ? (~t_val + (SUM_W+1)'(1)) : t_val;
      assign t_mag      = t_abs[MAG_W-1:0];
      assign mean_prod  = PROD_W'(t_mag) * PROD_W'(MEAN_M_C);
      assign mean_q     = mean_prod[MEAN_K +: ACCEL_W];
      assign mean_c[a]  = t_neg ? $signed(~mean_q + ACCEL_W'(1)) : $signed(mean_q);

      // capture in the same transaction as a report gives zero difference
      assign diff_c[a] = eff_cap ? '0 : DIFF_W'(mean_c[a]) - DIFF_W'(ref_ff[a]);
      assign ref_in[a] = (accept && !filling && eff_cap) ? mean_c[a] : ref_ff[a];

      // stage 2: magnitude quotients by reciprocal multiply
      assign d_neg      = s1_diff_ff[a][DIFF_W-1];
      assign d_abs_full = d_neg ? (~s1_diff_ff[a] + DIFF_W'(1)) : s1_diff_ff[a];
      assign d_abs      = d_abs_full[MAG_DIFF_W-1:0];
      assign p26        = (MAG_DIFF_W+DIV26_M_W)'(d_abs) * (MAG_DIFF_W+DIV26_M_W)'(DIV26_M);
      assign q26_c[a]   = p26[DIV26_K +: Q26_W];
      assign x5         = X5_W'({d_abs, 2'b00}) + X5_W'(d_abs);
      assign p13        = (X5_W+DIV13_M_W)'(x5) * (X5_W+DIV13_M_W)'(DIV13_M);
      assign q13_c[a]   = p13[DIV13_K +: Q13_W];

      // stage 3: scale, sign and mode select
      assign milli_mag = MILLI_W'(s2_q26_ff[a]) * MILLI_W'(MILLI_SCALE);
      always_comb begin
         case (s2_mode_ff)
            MODE_RAW:       conv_mag = '0;
            MODE_MILLI_MS2: conv_mag = VALUE_W'(milli_mag);
            default:        conv_mag = VALUE_W'(s2_q13_ff[a]);
         endcase
         if (s2_mode_ff == MODE_RAW) begin
            value_c[a] = VALUE_W'(s2_raw_ff[a]);
         end else begin
            value_c[a] = s2_neg_ff[a] ? $signed(~conv_mag + VALUE_W'(1))
                                      : $signed(conv_mag);
         end
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_mode_ff      <= MODE_RAW;
         report_period_ff  <= DEF_PERIOD;
         report_counter_ff <= '0;
         fill_ff           <= '0;
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         for (int a = 0; a < NUM_AXES; a++) begin
            sum_ff[a] <= '0;
            ref_ff[a] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_UNIT_MODE:     unit_mode_ff     <= csr_wdata[MODE_W-1:0];
               CSR_REPORT_PERIOD: report_period_ff <= csr_wdata[PERIOD_W-1:0];
               default:           ;
            endcase
         end
         report_counter_ff <= report_counter_in;
         fill_ff           <= fill_in;
         s1_valid_ff       <= s1_valid_in;
         s2_valid_ff       <= s2_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         for (int a = 0; a < NUM_AXES; a++) begin
            if (accept) begin
               sum_ff[a] <= sum_in[a];
            end
            ref_ff[a] <= ref_in[a];
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff[0] <= sample_c;
         for (int i = 1; i < WINDOW; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
      if (s1_free) begin
         s1_mode_ff <= mode_c;
         for (int a = 0; a < NUM_AXES; a++) begin
            s1_diff_ff[a] <= diff_c[a];
         end
      end
      if (s2_free) begin
         s2_mode_ff <= s1_mode_ff;
         for (int a = 0; a < NUM_AXES; a++) begin
            s2_neg_ff[a] <= s1_diff_ff[a][DIFF_W-1];
            s2_raw_ff[a] <= s1_diff_ff[a];
            s2_q26_ff[a] <= q26_c[a];
            s2_q13_ff[a] <= q13_c[a];
         end
      end
      if (s3_free) begin
         rsp_mode_ff <= s2_mode_ff;
         for (int a = 0; a < NUM_AXES; a++) begin
            rsp_value_ff[a] <= value_c[a];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - NUM_AXES*VALUE_W)'(0),
                        rsp_value_ff[2], rsp_value_ff[1], rsp_value_ff[0]};
   assign rsp_tuser  = rsp_mode_ff;

   // ---------------------------------------------------------------- checks
   // input back-pressure only when every report stage holds a result
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff))
      else $error("input stalled with a free report stage");

   // a capture taken with a report yields zero differences
   a_cap_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && report_now && eff_cap) |=>
         (s1_diff_ff[0] == '0 && s1_diff_ff[1] == '0 && s1_diff_ff[2] == '0))
      else $error("capture with report gave nonzero difference");

   // the counter restarts at one after each report
   a_cnt_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && report_now) |=> (report_counter_ff == PERIOD_W'(1)))
      else $error("report counter not restarted after report");

endmodule

FILE: tb/accel_window_mean_with_reference_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for accel_window_mean_with_reference_core: directed and random
// sample streams against a built-in boxcar/reference predictor. Depends on awm_pkg.
module accel_window_mean_with_reference_core_test;
   import awm_pkg::*;

   // one expected report: per-axis values (x lowest) and the mode that was applied
   typedef struct {
      logic [NUM_AXES-1:0][VALUE_W-1:0] value;
      mode_type                         mode;
   } report_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;    // [9:0] x, [19:10] y, [29:20] z, rest zero
   logic                   req_tuser;    // [0] capture_reference
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;    // [16:0] x, [33:17] y, [50:34] z, rest zero
   logic [MODE_W-1:0]      rsp_tuser;    // [1:0] mode_used
   logic                   csr_we;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // predictor state: window taps, running sums, reference, report counter, registers
   int                     taps [NUM_AXES][DEF_WINDOW];
   int                     axis_sum [NUM_AXES] = '{0, 0, 0};
   int                     ref_level [NUM_AXES] = '{0, 0, 0};
   int                     tap_slot = 0;
   int                     fill_level = 0;
   int                     since_report = 0;
   logic [MODE_W-1:0]      cur_mode = MODE_RAW;
   logic [PERIOD_W-1:0]    cur_period = DEF_PERIOD;

   report_type             pending_reports [$];
   int                     mismatch_count = 0;

   // idle knobs, percent chance of a sender gap / receiver stall starting
   int                     idle_pct = 30;
   int                     stall_pct = 20;
   int                     stall_left = 0;

   accel_window_mean_with_reference_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // rounded boxcar mean, truncating divisions as in the spec
   function automatic int boxcar_mean(int total);
      return ((2 * total + DEF_WINDOW) / 2) / DEF_WINDOW;
   endfunction

   function automatic int to_units(int v, mode_type m);
      case (m)
         MODE_RAW:       return v;
         MODE_MILLI_MS2: return (v / 26) * 981;
         default:        return (v * 100) / 260;
      endcase
   endfunction

   // Advance the predictor by one accepted sample; queue a report if one is due.
   task automatic track_sample(input logic signed [ACCEL_W-1:0] ax, ay, az,
                               input logic cap);
      int         s [NUM_AXES];
      report_type r;
      mode_type   m;
      s[0] = ax;
      s[1] = ay;
      s[2] = az;
      if (fill_level < DEF_WINDOW) begin
         // fill: taps and sums only, capture flag has no effect
         for (int k = 0; k < NUM_AXES; k++) begin
            taps[k][tap_slot] = s[k];
            axis_sum[k] += s[k];
         end
         tap_slot = (tap_slot + 1) % DEF_WINDOW;
         fill_level++;
         if (fill_level == DEF_WINDOW)
            for (int k = 0; k < NUM_AXES; k++) ref_level[k] = boxcar_mean(axis_sum[k]);
         return;
      end
      // capture uses the window before this sample, and precedes the report
      if (cap)
         for (int k = 0; k < NUM_AXES; k++) ref_level[k] = boxcar_mean(axis_sum[k]);
      if (since_report >= cur_period) begin
         m = (cur_mode > MODE_CENTI_G) ? MODE_CENTI_G : mode_type'(cur_mode);
         for (int k = 0; k < NUM_AXES; k++)
            r.value[k] = VALUE_W'(to_units(boxcar_mean(axis_sum[k]) - ref_level[k], m));
         r.mode = m;
         pending_reports.push_back(r);
         since_report = 0;
      end
      since_report = (since_report + 1) & 8'hFF;
      for (int k = 0; k < NUM_AXES; k++) begin
         axis_sum[k] += s[k] - taps[k][tap_slot];
         taps[k][tap_slot] = s[k];
      end
      tap_slot = (tap_slot + 1) % DEF_WINDOW;
   endtask

   // Send one sample transaction. Valid stays high between back-to-back samples;
   // it only drops when a gap is inserted.
   task automatic send_sample(input logic signed [ACCEL_W-1:0] ax, ay, az,
                              input logic cap);
      int gap;
      gap = 0;
      if ($urandom_range(99) < idle_pct)
         gap = ($urandom_range(9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;   // junk while idle
         req_tuser  <= 1'($urandom_range(1));
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, az, ay, ax};
      req_tuser  <= cap;
      do @(posedge clock); while (!req_tready);
      track_sample(ax, ay, az, cap);
   endtask

   // Sender pause: drain every expected report, then let the pipeline settle
   // (three report stages) before touching the registers.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes the unit mode register, then the report period register; only called while idle.
   task automatic write_config(input logic [MODE_W-1:0] mode,
                               input logic [PERIOD_W-1:0] period);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_UNIT_MODE;
      csr_wdata <= CSR_DATA_W'(mode);
      @(posedge clock);
      cur_mode  = mode;
      csr_addr  <= CSR_REPORT_PERIOD;
      csr_wdata <= period;
      @(posedge clock);
      cur_period = period;
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Fill phase: no reports, capture flag ignored. Period zero so that every
   // later sample reports.
   task automatic test_fill_phase();
      write_config(MODE_RAW, 8'd0);
      for (int i = 0; i < DEF_WINDOW; i++)
         send_sample(-10'sd512, 10'sd511, (i % 2 == 0) ? -10'sd512 : 10'sd511, i[0]);
   endtask

   // Full-scale swing against the reference taken at the end of the fill.
   task automatic test_extreme_samples();
      for (int i = 0; i < 5; i++)
         send_sample(10'sd511, -10'sd512, (i < 3) ? 10'sd511 : -10'sd512, 1'b0);
   endtask

   // Capture and report on the same sample: differences read zero.
   task automatic test_capture_with_report();
      send_sample(10'sd0, 10'sd0, 10'sd0, 1'b1);
      send_sample(10'sd100, -10'sd100, 10'sd5, 1'b0);
   endtask

   // Every unit mode, including the unused code three (reported as centi-g).
   task automatic test_unit_modes();
      for (int m = 0; m < 4; m++) begin
         wait_idle();
         write_config(MODE_W'(m), 8'd0);
         if (m % 2 == 0)
            send_sample(10'sd511, -10'sd512, 10'sd511, 1'b0);
         else
            send_sample(-10'sd512, 10'sd511, -10'sd512, 1'b0);
      end
   endtask

   // Period one, entered with the counter at one after the last report:
   // every sample reports.
   task automatic test_report_spacing();
      wait_idle();
      write_config(MODE_MILLI_MS2, 8'd1);
      send_sample(-10'sd300, 10'sd200, 10'sd77, 1'b0);
      send_sample(10'sd1, -10'sd1, 10'sd0, 1'b0);
      send_sample(10'sd260, -10'sd260, 10'sd26, 1'b0);
   endtask

   // One random phase: fixed registers, samples mostly wandering around a level
   // per axis (realistic sensor data) with some full-range noise.
   task automatic random_phase(input logic [MODE_W-1:0] mode,
                               input logic [PERIOD_W-1:0] period, input int count);
      int                       level [NUM_AXES];
      int                       v;
      logic signed [ACCEL_W-1:0] s [NUM_AXES];
      wait_idle();
      write_config(mode, period);
      case ($urandom_range(2))
         0:       idle_pct = 0;
         1:       idle_pct = 15;
         default: idle_pct = 45;
      endcase
      case ($urandom_range(2))
         0:       stall_pct = 0;
         1:       stall_pct = 15;
         default: stall_pct = 40;
      endcase
      for (int k = 0; k < NUM_AXES; k++) level[k] = int'($urandom_range(1023)) - 512;
      for (int i = 0; i < count; i++) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            if ($urandom_range(99) < 75) begin
               if ($urandom_range(49) == 0)
                  level[k] = int'($urandom_range(1023)) - 512;
               v = level[k] + int'($urandom_range(40)) - 20;
               if (v > 511) v = 511;
               if (v < -512) v = -512;
               s[k] = ACCEL_W'(v);
            end else begin
               s[k] = ACCEL_W'($urandom);
            end
         end
         send_sample(s[0], s[1], s[2], $urandom_range(9) == 0);
      end
   endtask

   task automatic test_random_traffic();
      int p;
      // longest period first: 255 needs a full counter run between reports
      random_phase(MODE_W'($urandom_range(3)), 8'd255, 260);
      for (int ph = 0; ph < 12; ph++) begin
         p = $urandom_range(99);
         if (p < 50)
            p = $urandom_range(4);
         else if (p < 85)
            p = $urandom_range(5, 25);
         else
            p = $urandom_range(26, 255);
         random_phase(MODE_W'($urandom_range(3)), PERIOD_W'(p), 20);
      end
   endtask

   // Receiver: random stalls, mostly short, some long, none in zero-stall phases.
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
         stall_left <= ($urandom_range(9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Report checker: each accepted transaction against the oldest expectation.
   always @(posedge clock) begin
      report_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected report, expected none, actual x %0d y %0d z %0d mode %0d",
                     $time, $signed(rsp_tdata[0 +: VALUE_W]),
                     $signed(rsp_tdata[VALUE_W +: VALUE_W]),
                     $signed(rsp_tdata[2*VALUE_W +: VALUE_W]), rsp_tuser);
            mismatch_count++;
         end else begin
            exp_r = pending_reports.pop_front();
            for (int k = 0; k < NUM_AXES; k++)
               if (rsp_tdata[k*VALUE_W +: VALUE_W] !== exp_r.value[k]) begin
                  $display("%0t: axis %0d value mismatch, expected %0d, actual %0d", $time, k,
                           $signed(exp_r.value[k]), $signed(rsp_tdata[k*VALUE_W +: VALUE_W]));
                  mismatch_count++;
               end
            if (rsp_tuser !== exp_r.mode) begin
               $display("%0t: mode_used mismatch, expected %0d, actual %0d", $time,
                        exp_r.mode, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = CSR_UNIT_MODE;
      csr_wdata  = '0;
      for (int k = 0; k < NUM_AXES; k++)
         for (int j = 0; j < DEF_WINDOW; j++) taps[k][j] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_fill_phase();
      test_extreme_samples();
      test_capture_with_report();
      test_unit_modes();
      test_report_spacing();
      test_random_traffic();

      // drain, then watch for anything stray
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // hang guard, far above the slowest legal run
   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

endmodule
